// ===== rtl/core/pvu_pkg.sv =====
`timescale 1ns / 1ps
package pvu_pkg;

   typedef enum logic [1:0] {
      KIND_P   = 2'd0,
      KIND_KEY = 2'd1,
      KIND_B   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLS_SHORT,
      CLS_SINGLE,
      CLS_MULTI,
      CLS_ERROR
   } frame_class_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int DUP_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  START_CODE_BYTE = 8'hB6;
   localparam logic [23:0] START_PREFIX    = 24'h000001;
   localparam logic [23:0] RECENT_RESET    = 24'hFFFFFF;

   localparam int SHORT_FRAME_LEN = 9;
   localparam int LATE_MARGIN     = 7;
   localparam int START_LEAD      = 3;

   localparam logic [DUP_W-1:0] DUP_MAX = 16'hFFFF;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ABORT = 1'b1;

   localparam logic [1:0] TYPE_BITS_KEY = 2'd0;
   localparam logic [1:0] TYPE_BITS_B   = 2'd2;

   // Maps the top two bits of the byte after a start code to an entry kind.
   function automatic kind_type kind_from_type_bits(input logic [1:0] bits);
      kind_type k;
      case (bits)
         TYPE_BITS_KEY: k = KIND_KEY;
         TYPE_BITS_B:   k = KIND_B;
         default:       k = KIND_P;
      endcase
      return k;
   endfunction

   // Maps the original index type; the unused code is treated as P.
   function automatic kind_type kind_from_index(input logic [1:0] code);
      kind_type k;
      case (code)
         KIND_KEY: k = KIND_KEY;
         KIND_B:   k = KIND_B;
         default:  k = KIND_P;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/packed_vop_unpacker_unit.sv =====
`timescale 1ns / 1ps
// One byte is accepted per cycle while the two-frame descriptor queue has room.
// A frame with a single entry is pushed into the descriptor queue when its last byte is accepted,
// and the back end then loads it into the registered output. A frame split at several start codes
// reads each code offset in B_FETCH through the code-offset RAM's registered read, then shows it in B_EMIT.
// When two finished frames are waiting, the input stalls until the back end drains one.
// Reset is synchronous and active high; it clears all control state.
module packed_vop_unpacker_unit #(
   parameter int MAX_CODES = 8,
   parameter int FRAME_LEN_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // data_byte [7:0], frame_base [39:8], frame_kind [41:40], zero [47:42]
   input  logic [pvu_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // entry_kind [1:0], entry_offset [33:2], entry_size [57:34], zero [63:58]
   output logic [pvu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // status [0]
   output logic                           rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_CODES + 1);
   localparam int IDX_W = $clog2(MAX_CODES);
   localparam int DESC_W = 2 + 1 + CNT_W + 2 + 32 + FRAME_LEN_BITS;
   localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

   pvu_pkg::queue_status_type q_status;
   logic                      push;
   logic [DESC_W-1:0]         push_desc;
   logic                      pop;
   logic [DESC_W-1:0]         head_desc;
   logic                      ram_we;
   logic [IDX_W:0]            ram_waddr;
   logic [FRAME_LEN_BITS-1:0] ram_wdata;
   logic                      ram_re;
   logic [IDX_W:0]            ram_raddr;
   logic [FRAME_LEN_BITS-1:0] ram_rdata;

   pvu_front #(
      .MAX_CODES      (MAX_CODES),
      .FRAME_LEN_BITS (FRAME_LEN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_desc  (push_desc),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata)
   );

   pvu_ram #(
      .WIDTH (FRAME_LEN_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pvu_desc_queue #(
      .WIDTH (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .head_data (head_desc),
      .status    (q_status)
   );

   pvu_back #(
      .MAX_CODES      (MAX_CODES),
      .FRAME_LEN_BITS (FRAME_LEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_desc  (head_desc),
      .pop        (pop),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/pvu_ram.sv =====
`timescale 1ns / 1ps
module pvu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pvu_desc_queue.sv =====
`timescale 1ns / 1ps
module pvu_desc_queue #(
   parameter int WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output pvu_pkg::queue_status_type status
);

   logic [WIDTH-1:0] slot_ff [pvu_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = slot_ff[rd_ptr_ff];
   assign status.full      = (count_ff == 2'(pvu_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != 2'd0);

endmodule

// ===== rtl/core/pvu_front.sv =====
`timescale 1ns / 1ps
module pvu_front #(
   parameter int MAX_CODES = 8,
   parameter int FRAME_LEN_BITS = 24,
   localparam int CNT_W = $clog2(MAX_CODES + 1),
   localparam int IDX_W = $clog2(MAX_CODES),
   localparam int DESC_W = 2 + 1 + CNT_W + 2 + 32 + FRAME_LEN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pvu_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   input  pvu_pkg::queue_status_type        q_status,
   output logic                             push,
   output logic [DESC_W-1:0]                push_desc,
   output logic                             ram_we,
   output logic [IDX_W:0]                   ram_waddr,
   output logic [FRAME_LEN_BITS-1:0]        ram_wdata
);

   typedef struct packed {
      pvu_pkg::frame_class_type  cls;
      logic                      bank;
      logic [CNT_W-1:0]          count;
      pvu_pkg::kind_type         kind0;
      logic [31:0]               base;
      logic [FRAME_LEN_BITS-1:0] len;
   } desc_type;

   logic [23:0]               recent_ff, recent_in;
   logic [FRAME_LEN_BITS-1:0] pos_ff, pos_in;
   logic                      pending_ff, pending_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   pvu_pkg::kind_type         kind0_ff, kind0_in;
   logic [FRAME_LEN_BITS-1:0] off0_ff, off0_in;
   logic [FRAME_LEN_BITS-1:0] off1_ff, off1_in;
   logic                      bank_ff, bank_in;
   logic                      aborted_ff, aborted_in;

   logic                      accept;
   logic [7:0]                data_byte;
   logic [31:0]               frame_base;
   logic [1:0]                frame_kind;
   logic [FRAME_LEN_BITS-1:0] len;
   logic [FRAME_LEN_BITS-1:0] code_off;
   logic                      match;
   logic [CNT_W-1:0]          cnt_eff;
   pvu_pkg::kind_type         kind0_eff;
   logic                      ok0;
   logic                      ok1;
   desc_type                  desc;

   assign data_byte  = req_tdata[7:0];
   assign frame_base = req_tdata[39:8];
   assign frame_kind = req_tdata[41:40];

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // The byte counter saturates, so the frame length is the counter plus one, saturated.
   assign len      = (&pos_ff) ? pos_ff : pos_ff + FRAME_LEN_BITS'(1);
   assign code_off = pos_ff - FRAME_LEN_BITS'(pvu_pkg::START_LEAD);
   assign match    = !pending_ff && (recent_ff == pvu_pkg::START_PREFIX)
                     && (data_byte == pvu_pkg::START_CODE_BYTE)
                     && (count_ff < CNT_W'(MAX_CODES));

   assign cnt_eff   = count_ff + CNT_W'(pending_ff);
   assign kind0_eff = (pending_ff && (count_ff == '0))
                      ? pvu_pkg::kind_from_type_bits(data_byte[7:6]) : kind0_ff;

   // A code counts only if its marker byte is not among the last three bytes.
   assign ok0 = (cnt_eff != '0)
                && (({1'b0, off0_ff} + (FRAME_LEN_BITS+1)'(pvu_pkg::LATE_MARGIN))
                    <= {1'b0, len});
   assign ok1 = (cnt_eff >= CNT_W'(2))
                && (({1'b0, off1_ff} + (FRAME_LEN_BITS+1)'(pvu_pkg::LATE_MARGIN))
                    <= {1'b0, len});

   always_comb begin
      recent_in  = recent_ff;
      pos_in     = pos_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      kind0_in   = kind0_ff;
      off0_in    = off0_ff;
      off1_in    = off1_ff;
      bank_in    = bank_ff;
      aborted_in = aborted_ff;
      push       = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = {bank_ff, count_ff[IDX_W-1:0]};
      ram_wdata  = code_off;

      desc.bank  = bank_ff;
      desc.count = cnt_eff;
      desc.base  = frame_base;
      desc.len   = len;
      desc.kind0 = kind0_eff;
      if (len < FRAME_LEN_BITS'(pvu_pkg::SHORT_FRAME_LEN)) begin
         desc.cls   = pvu_pkg::CLS_SHORT;
         desc.kind0 = pvu_pkg::kind_from_index(frame_kind);
      end else if (!ok0) begin
         desc.cls = pvu_pkg::CLS_ERROR;
      end else if (!ok1) begin
         desc.cls = pvu_pkg::CLS_SINGLE;
      end else begin
         desc.cls = pvu_pkg::CLS_MULTI;
      end
      if (aborted_ff) begin
         desc.cls = pvu_pkg::CLS_ERROR;
      end

      if (accept) begin
         if (!aborted_ff) begin
            if (pending_ff) begin
               pending_in = 1'b0;
               count_in   = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  kind0_in = kind0_eff;
               end
            end else if (match) begin
               ram_we     = 1'b1;
               pending_in = 1'b1;
               if (count_ff == CNT_W'(0)) begin
                  off0_in = code_off;
               end
               if (count_ff == CNT_W'(1)) begin
                  off1_in = code_off;
               end
            end
            recent_in = {recent_ff[15:0], data_byte};
            if (!req_tlast) begin
               pos_in = len;
            end
         end
         if (req_tlast) begin
            push       = 1'b1;
            bank_in    = ~bank_ff;
            recent_in  = pvu_pkg::RECENT_RESET;
            pos_in     = '0;
            pending_in = 1'b0;
            count_in   = '0;
            if (desc.cls == pvu_pkg::CLS_ERROR) begin
               aborted_in = 1'b1;
            end
         end
      end
   end

   assign push_desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff  <= pvu_pkg::RECENT_RESET;
         pos_ff     <= '0;
         pending_ff <= 1'b0;
         count_ff   <= '0;
         bank_ff    <= 1'b0;
         aborted_ff <= 1'b0;
      end else begin
         recent_ff  <= recent_in;
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         bank_ff    <= bank_in;
         aborted_ff <= aborted_in;
      end
   end

   always_ff @(posedge clock) begin
      kind0_ff <= kind0_in;
      off0_ff  <= off0_in;
      off1_ff  <= off1_in;
   end

endmodule

// ===== rtl/core/pvu_back.sv =====
`timescale 1ns / 1ps
module pvu_back #(
   parameter int MAX_CODES = 8,
   parameter int FRAME_LEN_BITS = 24,
   localparam int CNT_W = $clog2(MAX_CODES + 1),
   localparam int IDX_W = $clog2(MAX_CODES),
   localparam int DESC_W = 2 + 1 + CNT_W + 2 + 32 + FRAME_LEN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pvu_pkg::queue_status_type        q_status,
   input  logic [DESC_W-1:0]                head_desc,
   output logic                             pop,
   output logic                             ram_re,
   output logic [IDX_W:0]                   ram_raddr,
   input  logic [FRAME_LEN_BITS-1:0]        ram_rdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pvu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   typedef struct packed {
      pvu_pkg::frame_class_type  cls;
      logic                      bank;
      logic [CNT_W-1:0]          count;
      pvu_pkg::kind_type         kind0;
      logic [31:0]               base;
      logic [FRAME_LEN_BITS-1:0] len;
   } desc_type;

   pvu_pkg::back_state_type   state_ff, state_in;
   logic [IDX_W-1:0]          j_ff, j_in;
   logic [FRAME_LEN_BITS-1:0] start_ff, start_in;
   logic [pvu_pkg::DUP_W-1:0] dup_ff, dup_in;
   logic                      first_done_ff, first_done_in;
   logic                      out_valid_ff, out_valid_in;
   pvu_pkg::kind_type         out_kind_ff, out_kind_in;
   logic [31:0]               out_offset_ff, out_offset_in;
   logic [23:0]               out_size_ff, out_size_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_status_ff, out_status_in;

   desc_type                  head;
   logic                      out_free;
   logic                      have_next;
   logic [FRAME_LEN_BITS-1:0] stop_sel;
   logic                      load;
   pvu_pkg::kind_type         ld_kind;
   logic [FRAME_LEN_BITS-1:0] ld_start;
   logic [FRAME_LEN_BITS-1:0] ld_stop;
   logic                      ld_last;
   logic                      ld_status;
   logic [FRAME_LEN_BITS+31:0] start_wide;
   logic [FRAME_LEN_BITS+23:0] size_wide;

   assign head     = desc_type'(head_desc);
   assign out_free = !out_valid_ff || rsp_tready;

   // The next code ends this entry unless it is past the count or too close to the frame end.
   assign have_next = ((CNT_W'(j_ff) + CNT_W'(1)) < head.count)
                      && (({1'b0, ram_rdata} + (FRAME_LEN_BITS+1)'(pvu_pkg::LATE_MARGIN))
                          <= {1'b0, head.len});
   assign stop_sel  = have_next ? ram_rdata : head.len;
   assign ram_raddr = {head.bank, j_ff + IDX_W'(1)};

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      start_in      = start_ff;
      dup_in        = dup_ff;
      pop           = 1'b0;
      ram_re        = 1'b0;
      load          = 1'b0;
      ld_kind       = pvu_pkg::KIND_P;
      ld_start      = '0;
      ld_stop       = head.len;
      ld_last       = 1'b1;
      ld_status     = pvu_pkg::STATUS_OK;

      case (state_ff)
         pvu_pkg::B_IDLE: begin
            if (q_status.not_empty) begin
               case (head.cls)
                  pvu_pkg::CLS_SHORT: begin
                     if (dup_ff != '0) begin
                        dup_in = dup_ff - pvu_pkg::DUP_W'(1);
                        pop    = 1'b1;
                     end else if (out_free) begin
                        load    = 1'b1;
                        ld_kind = head.kind0;
                        pop     = 1'b1;
                     end
                  end
                  pvu_pkg::CLS_SINGLE: begin
                     if (out_free) begin
                        load    = 1'b1;
                        ld_kind = head.kind0;
                        pop     = 1'b1;
                     end
                  end
                  pvu_pkg::CLS_MULTI: begin
                     if (dup_ff != pvu_pkg::DUP_MAX) begin
                        dup_in = dup_ff + pvu_pkg::DUP_W'(1);
                     end
                     j_in     = '0;
                     start_in = '0;
                     state_in = pvu_pkg::B_FETCH;
                  end
                  default: begin
                     if (out_free) begin
                        load      = 1'b1;
                        ld_status = pvu_pkg::STATUS_ABORT;
                        pop       = 1'b1;
                     end
                  end
               endcase
            end
         end
         pvu_pkg::B_FETCH: begin
            ram_re   = 1'b1;
            state_in = pvu_pkg::B_EMIT;
         end
         pvu_pkg::B_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               ld_kind  = (j_ff == '0) ? head.kind0 : pvu_pkg::KIND_B;
               ld_start = start_ff;
               ld_stop  = stop_sel;
               ld_last  = !have_next;
               if (have_next) begin
                  j_in     = j_ff + IDX_W'(1);
                  start_in = stop_sel;
                  state_in = pvu_pkg::B_FETCH;
               end else begin
                  pop      = 1'b1;
                  state_in = pvu_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = pvu_pkg::B_IDLE;
         end
      endcase
   end

   assign start_wide = {32'd0, ld_start};
   assign size_wide  = {24'd0, ld_stop - ld_start};

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_offset_in = out_offset_ff;
      out_size_in   = out_size_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      first_done_in = first_done_ff;
      if (load) begin
         out_valid_in  = 1'b1;
         out_last_in   = ld_last;
         out_status_in = ld_status;
         if (ld_status == pvu_pkg::STATUS_OK) begin
            // The very first valid entry of the stream is always a key entry.
            out_kind_in   = first_done_ff ? ld_kind : pvu_pkg::KIND_KEY;
            first_done_in = 1'b1;
            out_offset_in = head.base + start_wide[31:0];
            out_size_in   = size_wide[23:0];
         end else begin
            out_kind_in   = pvu_pkg::KIND_P;
            out_offset_in = '0;
            out_size_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pvu_pkg::B_IDLE;
         dup_ff        <= '0;
         first_done_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dup_ff        <= dup_in;
         first_done_ff <= first_done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      start_ff      <= start_in;
      out_kind_ff   <= out_kind_in;
      out_offset_ff <= out_offset_in;
      out_size_ff   <= out_size_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_size_ff, out_offset_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

   a_busy_has_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pvu_pkg::B_IDLE) |-> q_status.not_empty)
      else $error("back end is splitting a frame with an empty queue");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pvu_pkg::B_EMIT) |-> (CNT_W'(j_ff) < head.count))
      else $error("entry index ran past the code count");

   a_dup_saturates: assert property (@(posedge clock) disable iff (reset)
      (dup_ff == pvu_pkg::DUP_MAX) |=> (dup_ff != '0))
      else $error("duplicate count wrapped");

endmodule
